// File: rtl/atld_pkg.sv
package atld_pkg;

	localparam int SAMPLE_BITS = 16;
	localparam int FRAC_BITS   = 12;
	localparam int COUNT_BITS  = 16;
	localparam int MEAN_BITS   = SAMPLE_BITS + FRAC_BITS;
	localparam int RATE_BITS   = 16;
	localparam int CFG_BITS    = 16;
	localparam int CFG_IDX_BITS = 3;
	localparam int REQ_BITS    = 2;

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_BITS-1:0] CFG_SAMPLE_MIN    = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_SAMPLE_MAX    = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_MIN_SEP       = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] CFG_LEARN_RATE    = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] CFG_DEAD_HALF     = 3'd4;
	localparam logic [CFG_IDX_BITS-1:0] CFG_CONFIRM_COUNT = 3'd5;

	localparam logic [CFG_BITS-1:0] RST_SAMPLE_MIN    = 16'd0;
	localparam logic [CFG_BITS-1:0] RST_SAMPLE_MAX    = 16'd4000;
	localparam logic [CFG_BITS-1:0] RST_MIN_SEP       = 16'd20;
	localparam logic [CFG_BITS-1:0] RST_LEARN_RATE    = 16'd3277;
	localparam logic [CFG_BITS-1:0] RST_DEAD_HALF     = 16'd9830;
	localparam logic [CFG_BITS-1:0] RST_CONFIRM_COUNT = 16'd3;

	// Request codes.
	localparam logic [REQ_BITS-1:0] REQ_LEARN  = 2'd0;
	localparam logic [REQ_BITS-1:0] REQ_DETECT = 2'd1;
	localparam logic [REQ_BITS-1:0] REQ_BOTH   = 2'd2;

	typedef struct packed {
		logic [CFG_BITS-1:0] sample_min;
		logic [CFG_BITS-1:0] sample_max;
		logic [CFG_BITS-1:0] min_separation;
		logic [CFG_BITS-1:0] learn_rate;
		logic [CFG_BITS-1:0] dead_half_fraction;
		logic [CFG_BITS-1:0] confirm_count;
	} cfg_t;

	typedef struct packed {
		logic                 level;
		logic                 calibrated;
		logic                 sample_valid;
		logic [MEAN_BITS-1:0] mean_high;
		logic [MEAN_BITS-1:0] mean_low;
	} res_t;

	// Exponential averaging step; the step is truncated so the mean never
	// overshoots the target.
	function automatic logic [MEAN_BITS-1:0] move_toward(
		input logic [MEAN_BITS-1:0] mean,
		input logic [MEAN_BITS-1:0] target,
		input logic [RATE_BITS-1:0] rate
	);
		logic                           up;
		logic [MEAN_BITS-1:0]           diff;
		logic [MEAN_BITS+RATE_BITS-1:0] prod;
		logic [MEAN_BITS-1:0]           step;
		up   = (target >= mean);
		diff = up ? (target - mean) : (mean - target);
		prod = diff * rate;
		step = prod[MEAN_BITS+RATE_BITS-1:RATE_BITS];
		return up ? (mean + step) : (mean - step);
	endfunction

endpackage

// File: rtl/atld_cfg_regs.sv
module atld_cfg_regs (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                wr_en,
	input  logic [atld_pkg::CFG_IDX_BITS-1:0]   wr_index,
	input  logic [atld_pkg::CFG_BITS-1:0]       wr_data,
	output atld_pkg::cfg_t                      cfg
);

	atld_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sample_min         <= atld_pkg::RST_SAMPLE_MIN;
			cfg_q.sample_max         <= atld_pkg::RST_SAMPLE_MAX;
			cfg_q.min_separation     <= atld_pkg::RST_MIN_SEP;
			cfg_q.learn_rate         <= atld_pkg::RST_LEARN_RATE;
			cfg_q.dead_half_fraction <= atld_pkg::RST_DEAD_HALF;
			cfg_q.confirm_count      <= atld_pkg::RST_CONFIRM_COUNT;
		end else if (wr_en) begin
			case (wr_index)
				atld_pkg::CFG_SAMPLE_MIN:    cfg_q.sample_min         <= wr_data;
				atld_pkg::CFG_SAMPLE_MAX:    cfg_q.sample_max         <= wr_data;
				atld_pkg::CFG_MIN_SEP:       cfg_q.min_separation     <= wr_data;
				atld_pkg::CFG_LEARN_RATE:    cfg_q.learn_rate         <= wr_data;
				atld_pkg::CFG_DEAD_HALF:     cfg_q.dead_half_fraction <= wr_data;
				atld_pkg::CFG_CONFIRM_COUNT: cfg_q.confirm_count      <= wr_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// File: rtl/atld_engine.sv
module atld_engine (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                step,
	input  logic [atld_pkg::REQ_BITS-1:0]       req_type,
	input  logic [atld_pkg::SAMPLE_BITS-1:0]    sample,
	input  atld_pkg::cfg_t                      cfg,
	output atld_pkg::res_t                      res
);

	localparam int MB = atld_pkg::MEAN_BITS;

	logic [MB-1:0]                     high_q, low_q;
	logic                              seeded_q, cal_q, level_q;
	logic [atld_pkg::COUNT_BITS-1:0]   run_q;

	logic                              valid, do_learn, do_detect;
	logic [MB-1:0]                     xq, high_mv, low_mv, sep_mag, dz;
	logic [MB+atld_pkg::RATE_BITS-1:0] dz_prod;
	logic [MB:0]                       thr_hi, thr_lo, mid_sum, x2;
	logic [MB-1:0]                     high_n, low_n, min_sep_q;
	logic                              seeded_n, cal_n, level_n, cand;
	logic [atld_pkg::COUNT_BITS-1:0]   run_n, run_inc;

	assign valid     = (sample >= cfg.sample_min) && (sample <= cfg.sample_max);
	assign do_learn  = valid && (req_type == atld_pkg::REQ_LEARN ||
		req_type == atld_pkg::REQ_BOTH);
	assign do_detect = valid && (req_type == atld_pkg::REQ_DETECT ||
		req_type == atld_pkg::REQ_BOTH);
	assign xq        = {sample, {atld_pkg::FRAC_BITS{1'b0}}};
	assign min_sep_q = {cfg.min_separation, {atld_pkg::FRAC_BITS{1'b0}}};

	// Both plateau updates and the dead-zone width are computed side by side
	// from the current means, so no multiplier feeds another one.
	assign high_mv = atld_pkg::move_toward(high_q, xq, cfg.learn_rate);
	assign low_mv  = atld_pkg::move_toward(low_q, xq, cfg.learn_rate);
	assign sep_mag = (high_q >= low_q) ? (high_q - low_q) : (low_q - high_q);
	assign dz_prod = sep_mag * cfg.dead_half_fraction;
	assign dz      = dz_prod[MB+atld_pkg::RATE_BITS-1:atld_pkg::RATE_BITS];

	// When the means have crossed the dead zone is negative, which moves the
	// thresholds the other way.
	always_comb begin
		if (high_q >= low_q) begin
			thr_hi = {1'b0, high_q} - {1'b0, dz};
			thr_lo = {1'b0, low_q} + {1'b0, dz};
		end else begin
			thr_hi = {1'b0, high_q} + {1'b0, dz};
			thr_lo = {1'b0, low_q} - {1'b0, dz};
		end
	end

	always_comb begin
		high_n   = high_q;
		low_n    = low_q;
		seeded_n = seeded_q;
		cal_n    = cal_q;
		if (do_learn) begin
			if (!seeded_q) begin
				high_n   = xq;
				low_n    = xq;
				seeded_n = 1'b1;
			end else if (!cal_q) begin
				if (xq > high_q) begin
					high_n = high_mv;
				end else if (xq < low_q) begin
					low_n = low_mv;
				end
				if (high_n >= low_n && (high_n - low_n) >= min_sep_q) begin
					cal_n = 1'b1;
				end
			end else begin
				if ({1'b0, xq} >= thr_hi) begin
					high_n = high_mv;
				end else if ({1'b0, xq} <= thr_lo) begin
					low_n = low_mv;
				end
			end
		end
	end

	// Detection sees the means as they stand after learning.
	assign x2      = {xq, 1'b0};
	assign mid_sum = {1'b0, high_n} + {1'b0, low_n};
	assign cand    = (x2 >= mid_sum);
	assign run_inc = (&run_q) ? run_q : run_q + 1'b1;

	always_comb begin
		level_n = level_q;
		run_n   = run_q;
		if (do_detect && cal_n) begin
			if (cand != level_q) begin
				if (run_inc >= cfg.confirm_count) begin
					level_n = cand;
					run_n   = '0;
				end else begin
					run_n = run_inc;
				end
			end else begin
				run_n = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			high_q   <= '0;
			low_q    <= '0;
			seeded_q <= 1'b0;
			cal_q    <= 1'b0;
			level_q  <= 1'b0;
			run_q    <= '0;
		end else if (step) begin
			high_q   <= high_n;
			low_q    <= low_n;
			seeded_q <= seeded_n;
			cal_q    <= cal_n;
			level_q  <= level_n;
			run_q    <= run_n;
		end
	end

	always_comb begin
		res.level        = level_n;
		res.calibrated   = cal_n;
		res.sample_valid = valid;
		res.mean_high    = high_n;
		res.mean_low     = low_n;
	end

endmodule

// File: rtl/adaptive_two_level_detector_top.sv
// Adaptive two-level detector. Takes one transaction per clock cycle while in_stall is low
// and returns one result per transaction: the sample is captured in an input register, the
// plateau means, calibration flag and level are updated from it, and the result lands in an
// output register that drives the outputs; out_stall can hold a result back in between. The
// state update loop, with the averaging multiply followed by the midpoint compare, sets the
// clock rate. Configuration writes are always ready and take effect on the next cycle; write
// them only while the block is idle.
module adaptive_two_level_detector_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [atld_pkg::REQ_BITS-1:0]       req_type,
	input  logic [atld_pkg::SAMPLE_BITS-1:0]    sample,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic                                level,
	output logic                                calibrated,
	output logic                                sample_valid,
	output logic [atld_pkg::MEAN_BITS-1:0]      mean_high,
	output logic [atld_pkg::MEAN_BITS-1:0]      mean_low,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [atld_pkg::CFG_IDX_BITS-1:0]   cfg_index,
	input  logic [atld_pkg::CFG_BITS-1:0]       cfg_data
);

	atld_pkg::cfg_t                       cfg;
	atld_pkg::res_t                       res, res_s2;
	logic                                 v_s1, v_s2, adv1, adv2, step;
	logic [atld_pkg::REQ_BITS-1:0]        req_s1;
	logic [atld_pkg::SAMPLE_BITS-1:0]     sample_s1;

	assign cfg_ready = 1'b1;

	atld_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	assign adv2     = !v_s2 || !out_stall;
	assign adv1     = !v_s1 || adv2;
	assign in_stall = !adv1;
	assign step     = v_s1 && adv2;

	atld_engine u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (step),
		.req_type (req_s1),
		.sample   (sample_s1),
		.cfg      (cfg),
		.res      (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (adv1) begin
				v_s1 <= in_valid;
			end
			if (adv2) begin
				v_s2 <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv1 && in_valid) begin
			req_s1    <= req_type;
			sample_s1 <= sample;
		end
		if (step) begin
			res_s2 <= res;
		end
	end

	assign out_valid    = v_s2;
	assign level        = res_s2.level;
	assign calibrated   = res_s2.calibrated;
	assign sample_valid = res_s2.sample_valid;
	assign mean_high    = res_s2.mean_high;
	assign mean_low     = res_s2.mean_low;

endmodule

// File: tb/testbench.sv
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import atld_pkg::*;

	// Request code 3 has no name in the package; the block must treat it as a no-op.
	localparam logic [REQ_BITS-1:0]     REQ_NONE     = 2'd3;
	// Indexes past the last register.
	localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_LO = 3'd6;
	localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_HI = 3'd7;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int RANDOM_PHASES = 8;
	localparam int PHASE_ITEMS   = 100;

	logic                    clk       = 1'b0;
	logic                    arst_n    = 1'b0;
	logic                    in_valid  = 1'b0;
	logic                    in_stall;
	logic [REQ_BITS-1:0]     req_type  = REQ_LEARN;
	logic [SAMPLE_BITS-1:0]  sample    = '0;
	logic                    out_valid;
	logic                    out_stall = 1'b0;
	logic                    level;
	logic                    calibrated;
	logic                    sample_valid;
	logic [MEAN_BITS-1:0]    mean_high;
	logic [MEAN_BITS-1:0]    mean_low;
	logic                    cfg_valid = 1'b0;
	logic                    cfg_ready;
	logic [CFG_IDX_BITS-1:0] cfg_index = CFG_SAMPLE_MIN;
	logic [CFG_BITS-1:0]     cfg_data  = '0;

	// Predictor state, mirroring the block.
	cfg_t                  shadow;
	logic [MEAN_BITS-1:0]  hi_mean;
	logic [MEAN_BITS-1:0]  lo_mean;
	logic                  seeded;
	logic                  calib;
	logic                  lvl;
	logic [COUNT_BITS-1:0] run_len;
	res_t                  expected_readouts[$];

	logic tx_jitter = 1'b0;
	logic rx_jitter = 1'b0;
	int   errors          = 0;
	int   items_sent      = 0;
	int   results_checked = 0;
	int   level_changes   = 0;
	int   cfg_writes      = 0;

	adaptive_two_level_detector_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.req_type     (req_type),
		.sample       (sample),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.level        (level),
		.calibrated   (calibrated),
		.sample_valid (sample_valid),
		.mean_high    (mean_high),
		.mean_low     (mean_low),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #6 clk = ~clk;

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("%0t: timeout after %0d cycles", $time, CYCLE_LIMIT);
		$display("DONE: errors detected");
		$finish;
	end

	// Exponential averaging with a truncated step, so the mean never passes the target.
	function automatic logic [MEAN_BITS-1:0] chase(input logic [MEAN_BITS-1:0] m,
			input logic [MEAN_BITS-1:0] target);
		logic [MEAN_BITS+RATE_BITS-1:0] prod;
		if (target >= m) begin
			prod = (target - m) * shadow.learn_rate;
			return m + prod[MEAN_BITS+RATE_BITS-1:RATE_BITS];
		end
		prod = (m - target) * shadow.learn_rate;
		return m - prod[MEAN_BITS+RATE_BITS-1:RATE_BITS];
	endfunction

	task automatic learn_sample(input logic [MEAN_BITS-1:0] xq);
		longint h, l, x, frac, dz;
		h = longint'(hi_mean);
		l = longint'(lo_mean);
		x = longint'(xq);
		frac = longint'(shadow.dead_half_fraction);
		if (!seeded) begin
			hi_mean = xq;
			lo_mean = xq;
			seeded = 1'b1;
		end else if (!calib) begin
			if (xq > hi_mean)
				hi_mean = chase(hi_mean, xq);
			else if (xq < lo_mean)
				lo_mean = chase(lo_mean, xq);
			if (hi_mean >= lo_mean &&
					(hi_mean - lo_mean) >= (shadow.min_separation << FRAC_BITS))
				calib = 1'b1;
		end else begin
			// The dead zone keeps the sign of the separation when the means have crossed.
			if (h >= l)
				dz = ((h - l) * frac) >>> 16;
			else
				dz = -(((l - h) * frac) >>> 16);
			if (x >= h - dz)
				hi_mean = chase(hi_mean, xq);
			else if (x <= l + dz)
				lo_mean = chase(lo_mean, xq);
		end
	endtask

	task automatic detect_sample(input logic [MEAN_BITS-1:0] xq);
		logic cand;
		if (calib) begin
			cand = ({1'b0, xq, 1'b0} >= ({2'b00, hi_mean} + {2'b00, lo_mean}));
			if (cand != lvl) begin
				if (run_len != '1)
					run_len++;
				if (run_len >= shadow.confirm_count) begin
					lvl = cand;
					run_len = '0;
					level_changes++;
				end
			end else begin
				run_len = '0;
			end
		end
	endtask

	task automatic advance_detector(input logic [REQ_BITS-1:0] req,
			input logic [SAMPLE_BITS-1:0] s);
		logic                 in_range;
		logic [MEAN_BITS-1:0] xq;
		res_t                 r;
		in_range = (s >= shadow.sample_min) && (s <= shadow.sample_max);
		xq = {s, {FRAC_BITS{1'b0}}};
		if (in_range) begin
			if (req == REQ_LEARN || req == REQ_BOTH)
				learn_sample(xq);
			if (req == REQ_DETECT || req == REQ_BOTH)
				detect_sample(xq);
		end
		r.level = lvl;
		r.calibrated = calib;
		r.sample_valid = in_range;
		r.mean_high = hi_mean;
		r.mean_low = lo_mean;
		expected_readouts.push_back(r);
	endtask

	function automatic int unsigned pick_gap();
		int unsigned r;
		if (!tx_jitter)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	task automatic send_reading(input logic [REQ_BITS-1:0] req,
			input logic [SAMPLE_BITS-1:0] s);
		int unsigned gap;
		@(negedge clk);
		in_valid <= 1'b1;
		req_type <= req;
		sample <= s;
		// Hold the transaction until the block takes it.
		do @(posedge clk); while (in_stall);
		advance_detector(req, s);
		items_sent++;
		gap = pick_gap();
		if (gap != 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	task automatic wait_for_quiet();
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_readouts.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_setting(input logic [CFG_IDX_BITS-1:0] idx,
			input logic [CFG_BITS-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_SAMPLE_MIN:    shadow.sample_min = val;
			CFG_SAMPLE_MAX:    shadow.sample_max = val;
			CFG_MIN_SEP:       shadow.min_separation = val;
			CFG_LEARN_RATE:    shadow.learn_rate = val;
			CFG_DEAD_HALF:     shadow.dead_half_fraction = val;
			CFG_CONFIRM_COUNT: shadow.confirm_count = val;
			default: ;
		endcase
		cfg_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic apply_settings(input logic [CFG_BITS-1:0] lo_bound, hi_bound, sep, rate,
			dead_half, confirm);
		write_setting(CFG_SAMPLE_MIN, lo_bound);
		write_setting(CFG_SAMPLE_MAX, hi_bound);
		write_setting(CFG_MIN_SEP, sep);
		write_setting(CFG_LEARN_RATE, rate);
		write_setting(CFG_DEAD_HALF, dead_half);
		write_setting(CFG_CONFIRM_COUNT, confirm);
	endtask

	task automatic compare_field(input string name, input logic [MEAN_BITS-1:0] want, got);
		if (want !== got) begin
			errors++;
			if (errors <= 40)
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
		end
	endtask

	always @(posedge clk) begin : readout_check
		res_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_readouts.size() == 0) begin
				errors++;
				if (errors <= 40)
					$display("%0t: result arrived with nothing expected", $time);
			end else begin
				want = expected_readouts.pop_front();
				results_checked++;
				compare_field("level", MEAN_BITS'(want.level), MEAN_BITS'(level));
				compare_field("calibrated", MEAN_BITS'(want.calibrated),
					MEAN_BITS'(calibrated));
				compare_field("sample_valid", MEAN_BITS'(want.sample_valid),
					MEAN_BITS'(sample_valid));
				compare_field("mean_high", want.mean_high, mean_high);
				compare_field("mean_low", want.mean_low, mean_low);
			end
		end
	end

	// Receiver back-pressure: mostly short stalls, now and then a long one.
	initial begin : stall_driver
		int unsigned hold;
		hold = 0;
		forever begin
			@(negedge clk);
			if (hold != 0)
				hold--;
			else if (rx_jitter && $urandom_range(0, 99) < 30)
				hold = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
					: $urandom_range(1, 3);
			out_stall <= (hold != 0);
		end
	end

	// Before any sample is learned the means are zero, and detection does nothing uncalibrated.
	task automatic test_idle_state();
		send_reading(REQ_NONE, 16'd1234);
		send_reading(REQ_DETECT, 16'd4000);
		send_reading(REQ_LEARN, 16'hFFFF);
		send_reading(REQ_BOTH, 16'd4001);
		wait_for_quiet();
	endtask

	// With zero learning rate the means freeze at the seed, so the midpoint is exact and a
	// sample on it must count as high. Zero confirm count switches on the first disagreement.
	task automatic test_seed_and_midpoint();
		write_setting(CFG_MIN_SEP, 16'd0);
		write_setting(CFG_LEARN_RATE, 16'd0);
		write_setting(CFG_CONFIRM_COUNT, 16'd0);
		send_reading(REQ_LEARN, 16'd2000);
		send_reading(REQ_LEARN, 16'd3000);
		send_reading(REQ_DETECT, 16'd2000);
		send_reading(REQ_DETECT, 16'd1999);
		send_reading(REQ_BOTH, 16'd0);
		wait_for_quiet();
	endtask

	task automatic test_dead_zone_and_confirm();
		write_setting(CFG_SAMPLE_MAX, 16'hFFFF);
		write_setting(CFG_LEARN_RATE, 16'hFFFF);
		write_setting(CFG_CONFIRM_COUNT, 16'd2);
		send_reading(REQ_LEARN, 16'd3000);
		send_reading(REQ_LEARN, 16'd1000);
		send_reading(REQ_BOTH, 16'd2000);
		send_reading(REQ_BOTH, 16'hFFFF);
		send_reading(REQ_BOTH, 16'hFFFF);
		send_reading(REQ_BOTH, 16'd0);
		send_reading(REQ_BOTH, 16'd0);
		wait_for_quiet();
	endtask

	task automatic test_range_limits();
		write_setting(CFG_SAMPLE_MIN, 16'd3000);
		write_setting(CFG_SAMPLE_MAX, 16'd1000);
		send_reading(REQ_BOTH, 16'd2000);
		send_reading(REQ_LEARN, 16'd500);
		wait_for_quiet();
		write_setting(CFG_SAMPLE_MIN, 16'hFFFF);
		write_setting(CFG_SAMPLE_MAX, 16'hFFFF);
		write_setting(CFG_SPARE_LO, 16'hFFFF);
		write_setting(CFG_SPARE_HI, 16'h0000);
		send_reading(REQ_BOTH, 16'hFFFF);
		send_reading(REQ_BOTH, 16'hFFFE);
		wait_for_quiet();
		write_setting(CFG_SAMPLE_MIN, 16'd0);
		write_setting(CFG_SAMPLE_MAX, 16'd0);
		send_reading(REQ_BOTH, 16'd0);
		wait_for_quiet();
	endtask

	task automatic randomize_settings();
		int unsigned         lo_b, hi_b;
		logic [CFG_BITS-1:0] sep, rate, dead_half, confirm;
		lo_b = $urandom_range(0, 40000);
		hi_b = $urandom_range(lo_b + 500, 65535);
		sep = CFG_BITS'($urandom_range(0, 300));
		rate = CFG_BITS'($urandom_range(1, 65535));
		dead_half = ($urandom_range(0, 6) == 0) ? CFG_BITS'($urandom_range(32769, 65535))
			: CFG_BITS'($urandom_range(0, 32768));
		confirm = ($urandom_range(0, 9) == 0) ? CFG_BITS'($urandom_range(11, 65535))
			: CFG_BITS'($urandom_range(0, 10));
		apply_settings(CFG_BITS'(lo_b), CFG_BITS'(hi_b), sep, rate, dead_half, confirm);
	endtask

	// Noisy samples that dwell on one of two plateaus for runs of random length, plus some
	// out-of-range readings and stray request codes.
	task automatic plateau_burst(input int count);
		int                  span, lo_p, hi_p, noise, run_left, v;
		int unsigned         pick;
		logic                on_high;
		logic [REQ_BITS-1:0] req;
		span = int'(shadow.sample_max) - int'(shadow.sample_min);
		lo_p = int'(shadow.sample_min) + int'($urandom_range(0, span / 3));
		hi_p = int'(shadow.sample_max) - int'($urandom_range(0, span / 3));
		noise = int'($urandom_range(0, span / 20 + 1));
		on_high = 1'($urandom_range(0, 1));
		run_left = 0;
		for (int i = 0; i < count; i++) begin
			if (run_left == 0) begin
				on_high = !on_high;
				run_left = int'($urandom_range(1, 12));
			end
			run_left--;
			v = (on_high ? hi_p : lo_p) - noise + int'($urandom_range(0, 2 * noise));
			if (v < 0)
				v = 0;
			if (v > 65535)
				v = 65535;
			pick = $urandom_range(0, 99);
			if (pick < 4)
				v = int'($urandom_range(0, 65535));
			else if (pick < 8)
				v = (shadow.sample_max == '1) ? 0 : int'(shadow.sample_max) + 1;
			pick = $urandom_range(0, 99);
			if (pick < 70)
				req = REQ_BOTH;
			else if (pick < 80)
				req = REQ_LEARN;
			else if (pick < 95)
				req = REQ_DETECT;
			else
				req = REQ_NONE;
			send_reading(req, v[SAMPLE_BITS-1:0]);
			if ($urandom_range(0, 99) == 0)
				wait_for_quiet();
		end
	endtask

	task automatic test_plateau_traffic();
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			tx_jitter = (p % 3 != 0);
			rx_jitter = (p % 4 != 1);
			case (p)
				0: apply_settings(RST_SAMPLE_MIN, RST_SAMPLE_MAX, RST_MIN_SEP, RST_LEARN_RATE,
					RST_DEAD_HALF, RST_CONFIRM_COUNT);
				1: apply_settings(16'd100, 16'd60000, 16'd0, 16'hFFFF, 16'd0, 16'd0);
				2: apply_settings(16'd0, 16'hFFFF, 16'hFFFF, 16'd1, 16'd32768, 16'hFFFF);
				default: randomize_settings();
			endcase
			plateau_burst(PHASE_ITEMS);
			wait_for_quiet();
		end
	endtask

	initial begin
		shadow.sample_min = RST_SAMPLE_MIN;
		shadow.sample_max = RST_SAMPLE_MAX;
		shadow.min_separation = RST_MIN_SEP;
		shadow.learn_rate = RST_LEARN_RATE;
		shadow.dead_half_fraction = RST_DEAD_HALF;
		shadow.confirm_count = RST_CONFIRM_COUNT;
		hi_mean = '0;
		lo_mean = '0;
		seeded = 1'b0;
		calib = 1'b0;
		lvl = 1'b0;
		run_len = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_idle_state();
		test_seed_and_midpoint();
		test_dead_zone_and_confirm();
		test_range_limits();
		test_plateau_traffic();

		wait_for_quiet();
		repeat (8) @(posedge clk);
		if (expected_readouts.size() != 0) begin
			errors++;
			$display("%0t: %0d results never arrived", $time, expected_readouts.size());
		end
		$display("Checked %0d results from %0d samples over %0d register writes;",
			results_checked, items_sent, cfg_writes);
		$display("%0d level changes, final means high %0d, low %0d (Q16.12), calibrated %0b.",
			level_changes, hi_mean, lo_mean, calib);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
